FILE: rtl/core/bytm_pkg.sv
// ============================================================================
// bytm_pkg
// Shared types, constants and arithmetic helpers for the yield solver.
// ============================================================================
package bytm_pkg;

    localparam int unsigned FRAC_BITS   = 40;
    localparam int unsigned MAX_PERIODS = 1024;
    localparam int unsigned PER_W       = 11;
    localparam int unsigned ITER_W      = 7;
    localparam logic [ITER_W-1:0] NEWTON_STEPS = 7'd100;
    localparam logic signed [63:0] Q_ONE  = 64'sh0000_0100_0000_0000;
    localparam logic signed [63:0] STEP_H = 64'sd109951163;
    localparam logic [63:0] TOL_RAW = 64'd110;
    localparam logic signed [63:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S_MIN = 64'sh8000_0000_0000_0000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FACE   = 2'd0;
    localparam logic [1:0] CFG_COUPON = 2'd1;
    localparam logic [1:0] CFG_PPY    = 2'd2;
    localparam logic [1:0] CFG_NPER   = 2'd3;

    // Operation codes of the shared divider.
    typedef enum logic [1:0] {
        DIV_FIXED = 2'd0,  // signed Q24.40 quotient (a << 40) / b
        DIV_UINT  = 2'd1   // plain unsigned integer quotient
    } div_op_t;

    typedef struct packed {
        logic    start;
        div_op_t op;
    } div_ctl_t;

    // Signed value from sign flag and magnitude, saturating.
    function automatic logic signed [63:0] make_signed(input logic neg,
                                                       input logic [63:0] mag);
        logic signed [63:0] r;
        if (neg) begin
            if (mag == 64'd0) r = 64'sd0;
            else if (mag > 64'h8000_0000_0000_0000) r = S_MIN;
            else r = -$signed(mag);
        end else begin
            if (mag[63]) r = S_MAX;
            else r = $signed(mag);
        end
        return r;
    endfunction

    function automatic logic [63:0] mag_of(input logic signed [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? S_MIN : S_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? S_MIN : S_MAX;
        return s[63:0];
    endfunction

endpackage

FILE: rtl/core/bytm_if.sv
// ============================================================================
// bytm_in_if / bytm_out_if
// Valid-ready channels that carry solver requests and solved yields.
// ============================================================================
interface bytm_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] mkt_price;
    logic [63:0] initial_guess;
    modport source (output valid, mkt_price, initial_guess, input ready);
    modport sink   (input valid, mkt_price, initial_guess, output ready);
endinterface

interface bytm_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] yield_result;
    modport source (output valid, yield_result, input ready);
    modport sink   (input valid, yield_result, output ready);
endinterface

FILE: rtl/core/bytm_mul.sv
// ============================================================================
// bytm_mul
// Multi-cycle signed Q24.40 multiplier built on one 32x32 partial product.
// ============================================================================
module bytm_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic               done,
    output logic signed [63:0] p
);
    // Four partial products, one per cycle, accumulated into 128 bits.
    logic [63:0]  ma_reg, mb_reg;
    logic         neg_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic [127:0] acc_reg;
    logic [31:0]  opa, opb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [63:0]  mag;

    always_comb
    begin
        opa = cnt_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
        opb = cnt_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
        pp  = opa * opb;
        pp_sh = {64'd0, pp} << (({6'd0, cnt_reg[0]} + {6'd0, cnt_reg[1]}) * 7'd32);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 3'd3)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= bytm_pkg::mag_of(a);
            mb_reg  <= bytm_pkg::mag_of(b);
            neg_reg <= a[63] ^ b[63];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + pp_sh;
        end
    end

    // Truncate by 40 fraction bits, saturate on overflow.
    always_comb
    begin
        if (acc_reg[127:104] != 24'd0) mag = '1;
        else mag = acc_reg[103:40];
        p = bytm_pkg::make_signed(neg_reg, mag);
    end
endmodule

FILE: rtl/core/bytm_div.sv
// ============================================================================
// bytm_div
// Radix-2 restoring divider, one quotient bit per cycle, shared by all
// divisions of the solver.
// ============================================================================
module bytm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  bytm_pkg::div_ctl_t ctl,
    input  logic [63:0]        a,
    input  logic [63:0]        b,
    output logic               done,
    output logic [63:0]        q
);
    logic [127:0] num_reg;
    logic [127:0] quo_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  mb_reg;
    logic         neg_reg;
    logic         fixed_reg;
    logic         zero_reg;
    logic         apos_reg;
    logic         anz_reg;
    logic [7:0]   cnt_reg;
    logic         busy_reg;
    logic [64:0]  rsh;
    logic [64:0]  rdiff;
    logic [63:0]  mag;

    assign rsh   = {rem_reg, num_reg[127]};
    assign rdiff = rsh - {1'b0, mb_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= 8'd0;
        end
        else
        begin
            done <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 8'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 8'd1;
                if (cnt_reg == 8'd127)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // One shift-and-subtract step per cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            fixed_reg <= (ctl.op == bytm_pkg::DIV_FIXED);
            rem_reg   <= '0;
            quo_reg   <= '0;
            if (ctl.op == bytm_pkg::DIV_FIXED)
            begin
                num_reg  <= {24'd0, bytm_pkg::mag_of(a), 40'd0};
                mb_reg   <= bytm_pkg::mag_of(b);
                neg_reg  <= a[63] ^ b[63];
                apos_reg <= !a[63];
            end
            else
            begin
                num_reg  <= {64'd0, a};
                mb_reg   <= b;
                neg_reg  <= 1'b0;
                apos_reg <= 1'b1;
            end
            zero_reg <= (b == 64'd0);
            anz_reg  <= (a != 64'd0);
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[126:0], 1'b0};
            if (rsh >= {1'b0, mb_reg})
            begin
                rem_reg <= rdiff[63:0];
                quo_reg <= {quo_reg[126:0], 1'b1};
            end
            else
            begin
                rem_reg <= rsh[63:0];
                quo_reg <= {quo_reg[126:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        mag = (quo_reg[127:64] != 64'd0) ? '1 : quo_reg[63:0];
        if (!fixed_reg) q = quo_reg[63:0];
        else if (zero_reg)
            q = !anz_reg ? 64'd0 : (apos_reg ? bytm_pkg::S_MAX : bytm_pkg::S_MIN);
        else q = bytm_pkg::make_signed(neg_reg, mag);
    end
endmodule

FILE: rtl/core/bond_yield_to_maturity_solver.sv
// ============================================================================
// bond_yield_to_maturity_solver
// Newton-iteration yield-to-maturity solver over a configured fixed bond.
// ============================================================================
//  channel | dir | payload                         | transfer when
//  in_ch   | in  | mkt_price, initial_guess        | valid && ready
//  out_ch  | out | yield_result                    | valid && ready
//  cfg     | in  | cfg_we, cfg_index, cfg_data     | cfg_we high
//
// A Newton step prices the bond at y and, outside the tolerance, at y+H:
// each period of a pricing is a multiply and a divide, each pricing adds a
// period-rate divide, and the update takes two more divides. A solve adds
// a coupon multiply and divide and runs at most 100 steps. ready is low
// from acceptance until the result transfer. Reset clears the sequencer and
// loads the register defaults.
// ============================================================================
module bond_yield_to_maturity_solver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    bytm_in_if.sink     in_ch,
    bytm_out_if.source  out_ch
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CPM   = 11'b00000000010,
        S_CPN   = 11'b00000000100,
        S_PPRE  = 11'b00000001000,
        S_BASE  = 11'b00000010000,
        S_MUL   = 11'b00000100000,
        S_DIV   = 11'b00001000000,
        S_CHECK = 11'b00010000000,
        S_DER   = 11'b00100000000,
        S_STEP  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg;
    logic [63:0] face_reg;
    logic [31:0] cpr_reg;
    logic [3:0]  ppy_reg;
    logic [10:0] nper_reg;
    logic signed [63:0] market_reg, y_reg, yev_reg, base_reg, g_reg, pv_reg;
    logic signed [63:0] coupon_reg, last_reg, p_reg, diff_reg;
    logic [1:0]  phase_reg;  // 0 price at y, 1 price at y+H, 2 deriv, 3 step
    logic [10:0] k_reg;
    logic [6:0]  it_reg;
    logic        sub_reg;    // sub-state toggles between waits and launches
    logic        mstart, mdone;
    logic signed [63:0] mp;
    bytm_pkg::div_ctl_t dctl;
    logic [63:0] da, db, dq;
    logic        ddone;
    logic [3:0]  ppy_eff;
    logic [10:0] n_eff;
    logic [63:0] cprod_reg;
    logic [31:0] cmul_a;
    logic [63:0] cmul;

    assign ppy_eff = (ppy_reg == 4'd0) ? 4'd1 : ppy_reg;
    assign n_eff   = (nper_reg > 11'(bytm_pkg::MAX_PERIODS)) ?
                     11'(bytm_pkg::MAX_PERIODS) : nper_reg;

    // Coupon product face * rate >> 32, one 32x32 half per cycle.
    assign cmul_a = sub_reg ? face_reg[63:32] : face_reg[31:0];
    assign cmul   = cmul_a * cpr_reg;

    bytm_mul u_mul (.clk, .rst_n, .start(mstart), .a(g_reg), .b(base_reg),
                    .done(mdone), .p(mp));
    bytm_div u_div (.clk, .rst_n, .ctl(dctl), .a(da), .b(db), .done(ddone), .q(dq));

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_reg <= 64'd109951162777600;
            cpr_reg  <= 32'd214748365;
            ppy_reg  <= 4'd2;
            nper_reg <= 11'd20;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bytm_pkg::CFG_FACE:   face_reg <= cfg_data;
                bytm_pkg::CFG_COUPON: cpr_reg  <= cfg_data[31:0];
                bytm_pkg::CFG_PPY:    ppy_reg  <= cfg_data[3:0];
                bytm_pkg::CFG_NPER:   nper_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Divider operand selection.
    always_comb
    begin
        dctl.start = 1'b0;
        dctl.op    = bytm_pkg::DIV_FIXED;
        da = '0;
        db = '0;
        case (state_reg)
            S_CPN:
            begin
                dctl.start = !sub_reg;
                dctl.op = bytm_pkg::DIV_UINT;
                da = cprod_reg;
                db = {60'd0, ppy_eff};
            end
            S_BASE:
            begin
                // Period rate: magnitude of the yield over the payment count.
                dctl.start = !sub_reg;
                dctl.op = bytm_pkg::DIV_UINT;
                da = bytm_pkg::mag_of(yev_reg);
                db = {60'd0, ppy_eff};
            end
            S_DIV:
            begin
                dctl.start = !sub_reg;
                da = (k_reg == n_eff) ? last_reg : coupon_reg;
                db = g_reg;
            end
            S_DER:
            begin
                dctl.start = !sub_reg;
                if (phase_reg == 2'd2)
                begin
                    da = bytm_pkg::sat_sub(pv_reg, p_reg);
                    db = bytm_pkg::STEP_H;
                end
                else
                begin
                    da = diff_reg;
                    db = base_reg;
                end
            end
            default: ;
        endcase
    end

    assign mstart = (state_reg == S_MUL) && !sub_reg;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.yield_result = y_reg;

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sub_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        market_reg <= bytm_pkg::make_signed(1'b0, in_ch.mkt_price);
                        y_reg  <= in_ch.initial_guess;
                        it_reg <= '0;
                        sub_reg <= 1'b0;
                        state_reg <= S_CPM;
                    end
                end
                S_CPM:
                begin
                    if (!sub_reg)
                    begin
                        cprod_reg <= cmul;
                        sub_reg   <= 1'b1;
                    end
                    else
                    begin
                        cprod_reg <= cmul + {32'd0, cprod_reg[63:32]};
                        sub_reg   <= 1'b0;
                        state_reg <= S_CPN;
                    end
                end
                S_CPN:
                begin
                    sub_reg <= 1'b1;
                    if (ddone)
                    begin
                        coupon_reg <= bytm_pkg::make_signed(1'b0, dq);
                        last_reg <= bytm_pkg::sat_add(bytm_pkg::make_signed(1'b0, dq),
                                    bytm_pkg::make_signed(1'b0, face_reg));
                        sub_reg   <= 1'b0;
                        state_reg <= S_PPRE;
                        phase_reg <= 2'd0;
                    end
                end
                S_PPRE:
                begin
                    yev_reg <= (phase_reg == 2'd0) ? y_reg :
                               bytm_pkg::sat_add(y_reg, bytm_pkg::STEP_H);
                    sub_reg   <= 1'b0;
                    state_reg <= S_BASE;
                end
                S_BASE:
                begin
                    sub_reg <= 1'b1;
                    if (ddone)
                    begin
                        base_reg <= bytm_pkg::sat_add(bytm_pkg::Q_ONE,
                                    yev_reg[63] ? $signed(64'd0 - dq) : $signed(dq));
                        g_reg  <= bytm_pkg::Q_ONE;
                        pv_reg <= '0;
                        k_reg  <= 11'd1;
                        sub_reg <= 1'b0;
                        state_reg <= (n_eff == 11'd0) ? S_CHECK : S_MUL;
                    end
                end
                S_MUL:
                begin
                    sub_reg <= 1'b1;
                    if (mdone)
                    begin
                        g_reg <= mp;
                        sub_reg <= 1'b0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    sub_reg <= 1'b1;
                    if (ddone)
                    begin
                        pv_reg  <= bytm_pkg::sat_add(pv_reg, dq);
                        sub_reg <= 1'b0;
                        k_reg   <= k_reg + 11'd1;
                        state_reg <= (k_reg == n_eff) ? S_CHECK : S_MUL;
                    end
                end
                S_CHECK:
                begin
                    if (phase_reg == 2'd0)
                    begin
                        p_reg    <= pv_reg;
                        diff_reg <= bytm_pkg::sat_sub(pv_reg, market_reg);
                        if (bytm_pkg::mag_of(bytm_pkg::sat_sub(pv_reg, market_reg))
                            < bytm_pkg::TOL_RAW)
                            state_reg <= S_OUT;
                        else
                        begin
                            phase_reg <= 2'd1;
                            state_reg <= S_PPRE;
                        end
                    end
                    else
                    begin
                        phase_reg <= 2'd2;
                        sub_reg   <= 1'b0;
                        state_reg <= S_DER;
                    end
                end
                S_DER:
                begin
                    sub_reg <= 1'b1;
                    if (ddone)
                    begin
                        sub_reg <= 1'b0;
                        if (phase_reg == 2'd2)
                        begin
                            base_reg <= dq;
                            if (dq == 64'd0) state_reg <= S_OUT;
                            else phase_reg <= 2'd3;
                        end
                        else
                        begin
                            y_reg  <= bytm_pkg::sat_sub(y_reg, dq);
                            state_reg <= S_STEP;
                        end
                    end
                end
                S_STEP:
                begin
                    it_reg <= it_reg + 7'd1;
                    phase_reg <= 2'd0;
                    state_reg <= (it_reg + 7'd1 == bytm_pkg::NEWTON_STEPS) ? S_OUT : S_PPRE;
                end
                S_OUT:
                begin
                    if (out_ch.ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // The iteration count never passes the Newton step limit.
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        it_reg <= bytm_pkg::NEWTON_STEPS || state_reg == S_IDLE)
        else $error("iteration count over limit");

    // A result stays offered until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.yield_result))
        else $error("result dropped before transfer");

    // No input is taken while a result is pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input ready while result pending");
endmodule
